/* hdl/sfoc_pkg.sv */
// sfoc_pkg: shared types, codes and reset values of the flap controller
`timescale 1ns / 1ps

package sfoc_pkg;

  // field widths
  localparam int unsigned OpW      = 2;
  localparam int unsigned MsW      = 16;
  localparam int unsigned HallW    = 12;
  localparam int unsigned AngleW   = 8;
  localparam int unsigned SwingW   = 7;
  localparam int unsigned EventW   = 3;
  localparam int unsigned TimerW   = 17;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // largest servo angle in degrees
  localparam logic [AngleW-1:0] AngleMax = AngleW'(180);

  // configuration reset values
  localparam logic              LeftSideRst   = 1'b0;
  localparam logic [HallW-1:0]  OpenThreshRst = HallW'(2500);
  localparam logic [HallW-1:0]  CloseThreshRst = HallW'(1500);
  localparam logic [MsW-1:0]    TimeoutRst    = MsW'(2000);
  localparam logic [AngleW-1:0] CenterRst     = AngleW'(90);
  localparam logic [SwingW-1:0] SwingRst      = SwingW'(45);

  // operation codes
  typedef enum logic [OpW-1:0] {
    OP_TICK   = 2'd0,
    OP_OPEN   = 2'd1,
    OP_CLOSE  = 2'd2,
    OP_UNUSED = 2'd3
  } op_e;

  // event codes
  typedef enum logic [EventW-1:0] {
    EV_NONE         = 3'd0,
    EV_OPEN_START   = 3'd1,
    EV_CLOSE_START  = 3'd2,
    EV_REACHED_OPEN = 3'd3,
    EV_REACHED_SHUT = 3'd4,
    EV_TIMEOUT      = 3'd5
  } event_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_LEFT_SIDE     = 3'd0,
    REG_OPEN_THRESH   = 3'd1,
    REG_CLOSE_THRESH  = 3'd2,
    REG_MOVE_TIMEOUT  = 3'd3,
    REG_REST_ANGLE    = 3'd4,
    REG_SWING_OFFSET  = 3'd5
  } reg_idx_e;

  // input transaction payload
  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic [MsW-1:0]   elapsed_ms;
    logic [HallW-1:0] hall_sample;
  } in_item_t;

  // result transaction payload
  typedef struct packed {
    logic              servo_write;
    logic [AngleW-1:0] servo_angle;
    logic [EventW-1:0] event_res;
    logic              is_open;
    logic              is_closing;
  } out_item_t;

  // configuration register contents
  typedef struct packed {
    logic              left_side;
    logic [HallW-1:0]  open_threshold;
    logic [HallW-1:0]  close_threshold;
    logic [MsW-1:0]    move_timeout_ms;
    logic [AngleW-1:0] rest_angle;
    logic [SwingW-1:0] swing_offset;
  } cfg_t;

  // flap state
  typedef struct packed {
    logic              open_flag;
    logic              opening_flag;
    logic              closing_flag;
    logic [TimerW-1:0] move_timer;
  } flap_state_t;

endpackage

/* hdl/sfoc_cfg_regs.sv */
// sfoc_cfg_regs: configuration register file of the flap controller
`timescale 1ns / 1ps

module sfoc_cfg_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [sfoc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sfoc_pkg::CfgDataW-1:0] cfg_wdata_i,
  output sfoc_pkg::cfg_t           cfg_o
);
  import sfoc_pkg::*;

  cfg_t cfg_q, cfg_d;

  // decode a register write, wider data is truncated to the register
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LEFT_SIDE:    cfg_d.left_side       = cfg_wdata_i[0];
        REG_OPEN_THRESH:  cfg_d.open_threshold  = cfg_wdata_i[HallW-1:0];
        REG_CLOSE_THRESH: cfg_d.close_threshold = cfg_wdata_i[HallW-1:0];
        REG_MOVE_TIMEOUT: cfg_d.move_timeout_ms = cfg_wdata_i[MsW-1:0];
        REG_REST_ANGLE:   cfg_d.rest_angle      = cfg_wdata_i[AngleW-1:0];
        REG_SWING_OFFSET: cfg_d.swing_offset    = cfg_wdata_i[SwingW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_side       <= LeftSideRst;
      cfg_q.open_threshold  <= OpenThreshRst;
      cfg_q.close_threshold <= CloseThreshRst;
      cfg_q.move_timeout_ms <= TimeoutRst;
      cfg_q.rest_angle      <= CenterRst;
      cfg_q.swing_offset    <= SwingRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/sfoc_step.sv */
// sfoc_step: next flap state and result for one transaction
`timescale 1ns / 1ps

module sfoc_step (
  input  sfoc_pkg::in_item_t    item_i,
  input  sfoc_pkg::cfg_t        cfg_i,
  input  sfoc_pkg::flap_state_t state_i,
  output sfoc_pkg::flap_state_t state_o,
  output sfoc_pkg::out_item_t   result_o
);
  import sfoc_pkg::*;

  logic [AngleW:0]   plus_sum;
  logic [AngleW-1:0] plus_angle;
  logic [AngleW-1:0] minus_angle;
  logic [AngleW-1:0] center_clamped;
  logic [AngleW-1:0] open_angle;
  logic [AngleW-1:0] close_angle;
  logic [TimerW:0]   timer_sum;
  logic [TimerW-1:0] timer_sat;
  logic              moving;
  logic              timed_out;
  logic              open_w;
  logic              opening_w;
  logic              closing_w;
  logic              wr;
  logic [AngleW-1:0] angle;
  event_e            ev;

  // servo angles, each clamped to the servo range
  assign plus_sum       = {1'b0, cfg_i.rest_angle} + (AngleW+1)'(cfg_i.swing_offset);
  assign plus_angle     = (plus_sum > (AngleW+1)'(AngleMax)) ? AngleMax
                                                             : plus_sum[AngleW-1:0];
  assign center_clamped = (cfg_i.rest_angle > AngleMax) ? AngleMax : cfg_i.rest_angle;

  always_comb begin
    if (cfg_i.rest_angle < AngleW'(cfg_i.swing_offset)) begin
      minus_angle = '0;
    end else if ((cfg_i.rest_angle - AngleW'(cfg_i.swing_offset)) > AngleMax) begin
      minus_angle = AngleMax;
    end else begin
      minus_angle = cfg_i.rest_angle - AngleW'(cfg_i.swing_offset);
    end
  end

  // the left flap opens towards the plus side
  assign open_angle  = cfg_i.left_side ? plus_angle : minus_angle;
  assign close_angle = cfg_i.left_side ? minus_angle : plus_angle;

  // saturating move timer and timeout compare
  assign moving    = state_i.opening_flag | state_i.closing_flag;
  assign timer_sum = {1'b0, state_i.move_timer} + (TimerW+1)'(item_i.elapsed_ms);
  assign timer_sat = timer_sum[TimerW] ? '1 : timer_sum[TimerW-1:0];
  assign timed_out = moving && (timer_sat >= TimerW'(cfg_i.move_timeout_ms));

  // command and tick handling
  always_comb begin
    state_o   = state_i;
    wr        = 1'b0;
    angle     = '0;
    ev        = EV_NONE;
    open_w    = state_i.open_flag;
    opening_w = state_i.opening_flag;
    closing_w = state_i.closing_flag;
    unique case (op_e'(item_i.operation))
      OP_OPEN: begin
        if (!state_i.open_flag) begin
          state_o.opening_flag = 1'b1;
          state_o.closing_flag = 1'b0;
          state_o.move_timer   = '0;
          wr                   = 1'b1;
          angle                = open_angle;
          ev                   = EV_OPEN_START;
        end
      end
      OP_CLOSE: begin
        if (state_i.open_flag) begin
          state_o.opening_flag = 1'b0;
          state_o.closing_flag = 1'b1;
          state_o.open_flag    = 1'b0;
          state_o.move_timer   = '0;
          wr                   = 1'b1;
          angle                = close_angle;
          ev                   = EV_CLOSE_START;
        end
      end
      OP_TICK: begin
        if (moving) begin
          state_o.move_timer = timer_sat;
        end
        // timeout ends the move, an opening move then counts as open
        if (timed_out) begin
          open_w    = state_i.open_flag | state_i.opening_flag;
          opening_w = 1'b0;
          closing_w = 1'b0;
          wr        = 1'b1;
          angle     = center_clamped;
          ev        = EV_TIMEOUT;
        end
        // end detection by the hall sensor
        if (opening_w && (item_i.hall_sample >= cfg_i.open_threshold)) begin
          opening_w = 1'b0;
          open_w    = 1'b1;
          wr        = 1'b1;
          angle     = center_clamped;
          ev        = EV_REACHED_OPEN;
        end else if (closing_w && (item_i.hall_sample <= cfg_i.close_threshold)) begin
          closing_w = 1'b0;
          wr        = 1'b1;
          angle     = center_clamped;
          ev        = EV_REACHED_SHUT;
        end
        state_o.open_flag    = open_w;
        state_o.opening_flag = opening_w;
        state_o.closing_flag = closing_w;
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

  assign result_o.servo_write = wr;
  assign result_o.servo_angle = angle;
  assign result_o.event_res   = ev;
  assign result_o.is_open     = state_o.open_flag;
  assign result_o.is_closing  = state_o.closing_flag;

endmodule

/* hdl/servo_flap_open_close_controller.sv */
// servo_flap_open_close_controller: top level of the servo flap controller
`timescale 1ns / 1ps

// channel   | handshake                  | payload
// input     | in_valid_i / in_ready_o    | in_data_i   (operation, elapsed_ms, hall_sample)
// result    | out_valid_o / out_ready_i  | out_data_o  (servo_write .. is_closing)
// config    | cfg_we_i                   | cfg_idx_i, cfg_wdata_i
//
// one transaction per cycle sustained while the result is not stalled
// a transaction passes the input register and the step logic into the result register
// the flap state is updated when a transaction moves from input to result register
// a stalled result holds the result register; the input register still takes one more
// reset clears flags, timer and valids and loads the configuration defaults

module servo_flap_open_close_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sfoc_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sfoc_pkg::out_item_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [sfoc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sfoc_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import sfoc_pkg::*;

  cfg_t        cfg;
  in_item_t    in_data_q;
  logic        in_valid_q;
  out_item_t   out_data_q;
  logic        out_valid_q;
  flap_state_t state_q;
  flap_state_t state_d;
  out_item_t   result;
  logic        advance;

  // configuration registers
  sfoc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // state update and result for the registered transaction
  sfoc_step u_step (
    .item_i   (in_data_q),
    .cfg_i    (cfg),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result)
  );

  // pipeline flow control
  assign advance    = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  // flap state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
